[sv/luhn_pkg.sv]
// ----------------------------------------------------------------------------
// Luhn classifier package
// Shared sizes and result codes for the Luhn card number classifier.
// ----------------------------------------------------------------------------
package luhn_pkg;

  // Decimal digits produced by the converter (digit counts 1 to 19).
  localparam int unsigned MAX_DIGITS = 19;

  // Card number width and fixed result field widths.
  localparam int unsigned IN_W    = 63;
  localparam int unsigned CLASS_W = 2;
  localparam int unsigned DCNT_W  = 5;

  // Stream data widths, padded to whole bytes.
  localparam int unsigned S_TDATA_W = ((IN_W + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W = ((CLASS_W + 1 + DCNT_W + 7) / 8) * 8;

  // Card class codes.
  localparam logic [CLASS_W-1:0] CLS_INVALID = 2'd0;
  localparam logic [CLASS_W-1:0] CLS_FIFTEEN = 2'd1;
  localparam logic [CLASS_W-1:0] CLS_SIXTEEN = 2'd2;
  localparam logic [CLASS_W-1:0] CLS_LEAD4   = 2'd3;

endpackage

[sv/luhn_card_number_classifier.sv]
// ----------------------------------------------------------------------------
// Luhn card number classifier
// Converts a binary card number to decimal, forms the Luhn sum, counts the
// digits and classifies the number by length and leading digits.
// ----------------------------------------------------------------------------
// The conversion starts on the accepting edge and runs through every input
// bit in the shift-and-add-3 binary to BCD converter. The scan then
// accumulates the Luhn sum modulo ten over every decimal digit. A final state
// forms the class and loads the output register; it waits there while an
// earlier result is still unclaimed. s_axis_tready is high only while the
// sequencer is idle, which it enters on the edge that loads the result, so a
// new request is accepted only once the previous one has reached the output
// register. The result waits in an output register, so the next request is
// accepted while it is still unclaimed.
// Output data: card_class, checksum_ok, digit_count from the lowest bit up.
// Numbers with more than MAX_DIGITS digits are taken modulo ten to the
// MAX_DIGITS.
module luhn_card_number_classifier
  import luhn_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [62:0] card_number, [63] zero
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [1:0] card_class, [2] checksum_ok, [7:3] digit_count
  output logic [M_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned BCD_W  = 4 * MAX_DIGITS;
  localparam int unsigned BCNT_W = $clog2(IN_W);
  localparam int unsigned IDX_W  = $clog2(MAX_DIGITS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [IN_W-1:0]    bin_q, bin_d;
  logic [BCD_W-1:0]   bcd_q, bcd_d, bcd_adj;
  logic [BCNT_W-1:0]  bit_cnt_q, bit_cnt_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [3:0]         sum_q, sum_d;
  logic [DCNT_W-1:0]  count_q, count_d;
  logic [3:0]         lead_q, lead_d;
  logic [3:0]         lead_lo_q, lead_lo_d;
  logic [3:0]         prev_q, prev_d;
  logic               out_valid_q, out_valid_d;
  logic [CLASS_W-1:0] out_class_q, out_class_d;
  logic               out_ok_q, out_ok_d;
  logic [DCNT_W-1:0]  out_count_q, out_count_d;

  logic [3:0]         digit;
  logic [4:0]         dbl;
  logic [4:0]         weight;
  logic [4:0]         sum_raw;
  logic               out_free;
  logic               sum_ok;
  logic [CLASS_W-1:0] cls;

  // Add-3 correction on every BCD digit ahead of the shift.
  always_comb begin
    for (int k = 0; k < int'(MAX_DIGITS); k++) begin
      if (bcd_q[4*k +: 4] >= 4'd5) begin
        bcd_adj[4*k +: 4] = bcd_q[4*k +: 4] + 4'd3;
      end else begin
        bcd_adj[4*k +: 4] = bcd_q[4*k +: 4];
      end
    end
  end

  // Luhn weight of the digit under scan: double every second digit.
  assign digit   = bcd_q[3:0];
  assign dbl     = {digit, 1'b0};
  always_comb begin
    if (!idx_q[0]) begin
      weight = {1'b0, digit};
    end else if (dbl > 5'd9) begin
      weight = dbl - 5'd9;
    end else begin
      weight = dbl;
    end
  end
  assign sum_raw = {1'b0, sum_q} + weight;

  assign out_free = !out_valid_q || m_axis_tready;
  assign sum_ok   = (sum_q == 4'd0);

  always_comb begin
    cls = CLS_INVALID;
    if (sum_ok) begin
      priority if (count_q == DCNT_W'(15) && lead_q == 4'd3 &&
                   (lead_lo_q == 4'd4 || lead_lo_q == 4'd7)) begin
        cls = CLS_FIFTEEN;
      end else if (count_q == DCNT_W'(16) && lead_q == 4'd5 &&
                   lead_lo_q >= 4'd1 && lead_lo_q <= 4'd5) begin
        cls = CLS_SIXTEEN;
      end else if ((count_q == DCNT_W'(16) || count_q == DCNT_W'(13)) &&
                   lead_q == 4'd4) begin
        cls = CLS_LEAD4;
      end else begin
        cls = CLS_INVALID;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    bin_d       = bin_q;
    bcd_d       = bcd_q;
    bit_cnt_d   = bit_cnt_q;
    idx_d       = idx_q;
    sum_d       = sum_q;
    count_d     = count_q;
    lead_d      = lead_q;
    lead_lo_d   = lead_lo_q;
    prev_d      = prev_q;
    out_valid_d = out_valid_q;
    out_class_d = out_class_q;
    out_ok_d    = out_ok_q;
    out_count_d = out_count_q;

    // drop the result once it is taken
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          bin_d     = s_axis_tdata[IN_W-1:0];
          bcd_d     = '0;
          bit_cnt_d = '0;
          state_d   = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_d     = {bcd_adj[BCD_W-2:0], bin_q[IN_W-1]};
        bin_d     = {bin_q[IN_W-2:0], 1'b0};
        bit_cnt_d = bit_cnt_q + 1'b1;
        if (bit_cnt_q == BCNT_W'(IN_W - 1)) begin
          idx_d     = '0;
          sum_d     = '0;
          count_d   = DCNT_W'(1);
          lead_d    = '0;
          lead_lo_d = '0;
          prev_d    = '0;
          state_d   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        bcd_d  = {4'd0, bcd_q[BCD_W-1:4]};
        sum_d  = (sum_raw >= 5'd10) ? 4'(sum_raw - 5'd10) : sum_raw[3:0];
        prev_d = digit;
        if (digit != 4'd0) begin
          count_d   = DCNT_W'(idx_q) + 1'b1;
          lead_d    = digit;
          lead_lo_d = prev_q;
        end
        idx_d = idx_q + 1'b1;
        if (idx_q == IDX_W'(MAX_DIGITS - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_d = 1'b1;
          out_class_d = cls;
          out_ok_d    = sum_ok;
          out_count_d = count_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q       <= bin_d;
    bcd_q       <= bcd_d;
    bit_cnt_q   <= bit_cnt_d;
    idx_q       <= idx_d;
    sum_q       <= sum_d;
    count_q     <= count_d;
    lead_q      <= lead_d;
    lead_lo_q   <= lead_lo_d;
    prev_q      <= prev_d;
    out_class_q <= out_class_d;
    out_ok_q    <= out_ok_d;
    out_count_q <= out_count_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = M_TDATA_W'({out_count_q, out_ok_q, out_class_q});

  a_accept_starts_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q == ST_CONV && bit_cnt_q == '0))
    else $error("accepted request did not start conversion");

  a_scan_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (idx_q <= IDX_W'(MAX_DIGITS - 1)))
    else $error("digit scan index out of range");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_count_q >= DCNT_W'(1) &&
                       out_count_q <= DCNT_W'(MAX_DIGITS)))
    else $error("digit count out of range");

  a_class_needs_checksum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_class_q != CLS_INVALID) |-> out_ok_q)
    else $error("valid class reported with failing checksum");

  a_fin_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && out_free) |=> (m_axis_tvalid && state_q == ST_IDLE))
    else $error("finished request not loaded into output register");

endmodule
